>>> hw/rtl/earliest_free_counter_dispatch_core_defines.svh
// ----------------------------------------------------------------------------
// Earliest-free counter dispatch: assertion macros
// Concurrent assertion wrappers, clocked on clk_i and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef EARLIEST_FREE_COUNTER_DISPATCH_CORE_DEFINES_SVH
`define EARLIEST_FREE_COUNTER_DISPATCH_CORE_DEFINES_SVH

`ifndef SYNTHESIS
// Property that must hold at every clock edge outside reset.
`define EFCD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// Antecedent in one cycle implies consequent in the next.
`define EFCD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);
`else
`define EFCD_ASSERT(lbl, prop, msg)
`define EFCD_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

>>> hw/rtl/efcd_pkg.sv
// ----------------------------------------------------------------------------
// Earliest-free counter dispatch: shared package
// Widths, scan result type and the saturating busy-time add.
// ----------------------------------------------------------------------------
package efcd_pkg;

  localparam int BusyW  = 32;
  localparam int TimeW  = 16;
  localparam int CntW   = 5;
  // Wide enough for any counter index up to 256 counters.
  localparam int IdxW   = 8;

  typedef struct packed {
    logic             done;
    logic [IdxW-1:0]  idx;
    logic [BusyW-1:0] val;
  } scan_res_t;

  function automatic logic [BusyW-1:0] sat_add(logic [BusyW-1:0] a, logic [TimeW-1:0] b);
    logic [BusyW:0] s;
    s = {1'b0, a} + {{(BusyW-TimeW+1){1'b0}}, b};
    return s[BusyW] ? {BusyW{1'b1}} : s[BusyW-1:0];
  endfunction

endpackage

>>> hw/rtl/efcd_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module efcd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> hw/rtl/efcd_scan.sv
// ----------------------------------------------------------------------------
// Earliest-free counter dispatch: minimum scan
// Walks RAM entries 0..n-1, one read a cycle, and keeps the least value
// (first index wins on ties).
// ----------------------------------------------------------------------------
module efcd_scan #(
  parameter int MAX_COUNTERS = 16,
  localparam int AddrW = (MAX_COUNTERS > 1) ? $clog2(MAX_COUNTERS) : 1
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic [AddrW-1:0]         last_i,
  input  logic [efcd_pkg::BusyW-1:0] rdata_i,
  output logic                     re_o,
  output logic [AddrW-1:0]         raddr_o,
  output efcd_pkg::scan_res_t      res_o
);
  import efcd_pkg::*;

  logic             issue_q, issue_d;
  logic [AddrW-1:0] addr_q, addr_d;
  logic             rdv_q;
  logic [AddrW-1:0] rd_idx_q;
  logic [AddrW-1:0] best_idx_q, best_idx_d;
  logic [BusyW-1:0] best_val_q, best_val_d;
  logic             take;

  always_comb begin
    issue_d = issue_q;
    addr_d  = addr_q;
    if (start_i) begin
      issue_d = 1'b1;
      addr_d  = '0;
    end else if (issue_q) begin
      if (addr_q == last_i) begin
        issue_d = 1'b0;
      end else begin
        addr_d = addr_q + 1'b1;
      end
    end
  end

  // first entry seeds the minimum
  assign take       = (rd_idx_q == '0) || (rdata_i < best_val_q);
  assign best_idx_d = take ? rd_idx_q : best_idx_q;
  assign best_val_d = take ? rdata_i : best_val_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      issue_q <= 1'b0;
      rdv_q   <= 1'b0;
    end else begin
      issue_q <= issue_d;
      rdv_q   <= issue_q;
    end
  end

  always_ff @(posedge clk_i) begin
    addr_q   <= addr_d;
    rd_idx_q <= addr_q;
    if (rdv_q) begin
      best_idx_q <= best_idx_d;
      best_val_q <= best_val_d;
    end
  end

  assign re_o       = issue_q;
  assign raddr_o    = addr_q;
  assign res_o.done = rdv_q && (rd_idx_q == last_i);
  assign res_o.idx  = IdxW'(best_idx_d);
  assign res_o.val  = best_val_d;

endmodule

>>> hw/rtl/earliest_free_counter_dispatch_core.sv
// ----------------------------------------------------------------------------
// Earliest-free counter dispatch core
// Hands jobs to the counter that is free first; busy-until times in a RAM.
// ----------------------------------------------------------------------------
// Usage:
//  - s_axis carries one item per job: tdata = service time, tuser = action
//    (0 dispatch, 1 clear all counters).
//  - m_axis returns one item per input item: assigned counter (0 on clear)
//    and the counter the next job would get.
//  - cfg_* writes the number of counters in use (0 acts as 1, values above
//    MAX_COUNTERS act as MAX_COUNTERS); write it only while the core is idle.
//  - Per item: clear goes straight to the result; a dispatch to an unused
//    counter writes it and, when it opens the last one, scans for the next
//    pick; a dispatch with all counters open writes the cached pick and scans
//    for the next, or scans twice right after a config write. The cost is
//    the one-entry-per-cycle minimum scan over the busy-until RAM read port.
//  - One item is in flight at a time; s_axis_tready_o is high only while
//    idle. A finished result sits in the output register, so the next item
//    is accepted while it waits; a stalled receiver only holds the core once
//    a second result is ready.
//  - Reset empties all counters (fill count to zero, RAM not swept) and sets
//    the counter count to 1. Entries past the fill count are never read.
// ----------------------------------------------------------------------------
`include "earliest_free_counter_dispatch_core_defines.svh"

module earliest_free_counter_dispatch_core #(
  parameter int MAX_COUNTERS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // slave side
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [15:0] s_axis_tdata_i,   // [15:0] service_time
  input  logic        s_axis_tuser_i,   // [0] action
  // master side
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [15:0] m_axis_tdata_o,   // [4:0] assigned_counter,
                                        // [9:5] next_counter, [15:10] zero
  // configuration
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [4:0]  cfg_data_i        // [4:0] num_counters
);
  import efcd_pkg::*;

  localparam int AddrW = (MAX_COUNTERS > 1) ? $clog2(MAX_COUNTERS) : 1;
  // active count never exceeds what the 5-bit register can hold
  localparam int NCap  = (MAX_COUNTERS > 31) ? 31 : MAX_COUNTERS;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_SCAN  = 4'b0010,
    ST_WRITE = 4'b0100,
    ST_FIN   = 4'b1000
  } state_e;

  state_e            state_q, state_d;
  logic [CntW-1:0]   num_q, num_d;
  logic [CntW-1:0]   opened_q, opened_d;    // fill count since last clear
  logic              phase_q, phase_d;      // 0: scan for pick, 1: scan for next
  logic              cache_vld_q, cache_vld_d;
  logic [AddrW-1:0]  cache_idx_q, cache_idx_d;
  logic [BusyW-1:0]  cache_val_q, cache_val_d;
  logic [AddrW-1:0]  idx_q, idx_d;
  logic [BusyW-1:0]  wval_q, wval_d;
  logic [TimeW-1:0]  t_q, t_d;
  logic [CntW-1:0]   asg_q, asg_d;
  logic [CntW-1:0]   nxt_q, nxt_d;
  logic              out_vld_q, out_vld_d;
  logic [CntW-1:0]   out_asg_q, out_asg_d;
  logic [CntW-1:0]   out_nxt_q, out_nxt_d;

  logic [CntW-1:0]   n;
  logic [CntW-1:0]   n_m1;
  logic [AddrW-1:0]  last_addr;
  logic              s_acc;
  logic              scan_start;
  logic              ram_we;
  logic              ram_re;
  logic [AddrW-1:0]  ram_raddr;
  logic [BusyW-1:0]  ram_rdata;
  scan_res_t         scan_res;

  // effective counter count
  always_comb begin
    if (num_q == '0) begin
      n = CntW'(1);
    end else if (num_q > CntW'(NCap)) begin
      n = CntW'(NCap);
    end else begin
      n = num_q;
    end
  end
  assign n_m1      = n - 1'b1;
  assign last_addr = AddrW'(n_m1);

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign s_acc           = s_axis_tvalid_i && s_axis_tready_o;
  assign cfg_ready_o     = 1'b1;

  always_comb begin
    state_d     = state_q;
    num_d       = num_q;
    opened_d    = opened_q;
    phase_d     = phase_q;
    cache_vld_d = cache_vld_q;
    cache_idx_d = cache_idx_q;
    cache_val_d = cache_val_q;
    idx_d       = idx_q;
    wval_d      = wval_q;
    t_d         = t_q;
    asg_d       = asg_q;
    nxt_d       = nxt_q;
    out_vld_d   = out_vld_q;
    out_asg_d   = out_asg_q;
    out_nxt_d   = out_nxt_q;
    scan_start  = 1'b0;
    ram_we      = 1'b0;

    if (out_vld_q && m_axis_tready_i) begin
      out_vld_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (s_acc) begin
          t_d = s_axis_tdata_i;
          if (s_axis_tuser_i) begin
            // clear: fill count back to zero, RAM contents left stale
            opened_d    = '0;
            cache_vld_d = 1'b0;
            asg_d       = '0;
            nxt_d       = CntW'(1);
            state_d     = ST_FIN;
          end else if (opened_q < n) begin
            // lowest unused counter
            idx_d    = AddrW'(opened_q);
            wval_d   = {{(BusyW-TimeW){1'b0}}, s_axis_tdata_i};
            opened_d = opened_q + 1'b1;
            asg_d    = opened_q + 1'b1;
            state_d  = ST_WRITE;
          end else if (cache_vld_q) begin
            // pick known from the previous item's scan
            idx_d   = cache_idx_q;
            wval_d  = sat_add(cache_val_q, s_axis_tdata_i);
            asg_d   = CntW'(cache_idx_q) + 1'b1;
            state_d = ST_WRITE;
          end else begin
            phase_d    = 1'b0;
            scan_start = 1'b1;
            state_d    = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (scan_res.done) begin
          if (!phase_q) begin
            idx_d   = AddrW'(scan_res.idx);
            wval_d  = sat_add(scan_res.val, t_q);
            asg_d   = CntW'(scan_res.idx) + 1'b1;
            state_d = ST_WRITE;
          end else begin
            nxt_d       = CntW'(scan_res.idx) + 1'b1;
            cache_idx_d = AddrW'(scan_res.idx);
            cache_val_d = scan_res.val;
            cache_vld_d = 1'b1;
            state_d     = ST_FIN;
          end
        end
      end
      ST_WRITE: begin
        // write lands before the next scan reads, so no forwarding needed
        ram_we      = 1'b1;
        cache_vld_d = 1'b0;
        if (opened_q < n) begin
          nxt_d   = opened_q + 1'b1;
          state_d = ST_FIN;
        end else begin
          phase_d    = 1'b1;
          scan_start = 1'b1;
          state_d    = ST_SCAN;
        end
      end
      ST_FIN: begin
        if (!out_vld_q || m_axis_tready_i) begin
          out_vld_d = 1'b1;
          out_asg_d = asg_q;
          out_nxt_d = nxt_q;
          state_d   = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    if (cfg_valid_i && cfg_ready_o) begin
      num_d       = cfg_data_i;
      cache_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      num_q       <= CntW'(1);
      opened_q    <= '0;
      phase_q     <= 1'b0;
      cache_vld_q <= 1'b0;
      out_vld_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      num_q       <= num_d;
      opened_q    <= opened_d;
      phase_q     <= phase_d;
      cache_vld_q <= cache_vld_d;
      out_vld_q   <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cache_idx_q <= cache_idx_d;
    cache_val_q <= cache_val_d;
    idx_q       <= idx_d;
    wval_q      <= wval_d;
    t_q         <= t_d;
    asg_q       <= asg_d;
    nxt_q       <= nxt_d;
    out_asg_q   <= out_asg_d;
    out_nxt_q   <= out_nxt_d;
  end

  efcd_ram #(
    .WIDTH (BusyW),
    .DEPTH (MAX_COUNTERS)
  ) u_busy_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (idx_q),
    .wdata_i (wval_q),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  efcd_scan #(
    .MAX_COUNTERS (MAX_COUNTERS)
  ) u_scan (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (scan_start),
    .last_i  (last_addr),
    .rdata_i (ram_rdata),
    .re_o    (ram_re),
    .raddr_o (ram_raddr),
    .res_o   (scan_res)
  );

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = {6'b0, out_nxt_q, out_asg_q};

  `EFCD_ASSERT(a_cache_only_when_full, cache_vld_q |-> (opened_q >= n), "cached pick while counters unused")
  `EFCD_ASSERT(a_scan_done_in_scan, scan_res.done |-> (state_q == ST_SCAN), "scan finished outside scan state")
  `EFCD_ASSERT(a_write_in_range, ram_we |-> (32'(idx_q) < 32'(n)), "write to inactive counter")
  `EFCD_ASSERT_NEXT(a_clear_to_fin, s_acc && s_axis_tuser_i, (state_q == ST_FIN) && (opened_q == '0), "clear did not finish")

endmodule

>>> dv/tb_earliest_free_counter_dispatch_core.sv
// ----------------------------------------------------------------------------
// Earliest-free counter dispatch core: self-checking testbench
// Drives jobs and clears over s_axis, rewrites the counter count between
// phases, and checks every m_axis item against a local dispatch predictor or a hand-typed grant.
// ----------------------------------------------------------------------------
module tb_earliest_free_counter_dispatch_core;
  timeunit 1ns;
  timeprecision 1ps;

  import efcd_pkg::*;

  localparam int unsigned NumCounters    = 16;
  localparam int unsigned LongHoldCycles = 200;
  localparam int unsigned WatchdogLimit  = 4000;
  localparam int unsigned DrainCycles    = 50;
  localparam int unsigned MaxReported    = 10;
  localparam int unsigned RandomPerPhase = 100;

  typedef enum bit {
    ActDispatch = 1'b0,
    ActClear    = 1'b1
  } job_action_e;

  typedef struct packed {
    logic [CntW-1:0] assigned;
    logic [CntW-1:0] next_up;
  } grant_t;

  // per-item note: pinned rows carry a hand-typed grant
  typedef struct packed {
    bit     pinned;
    grant_t value;
  } pinned_grant_t;

  typedef struct packed {
    bit               wr_cfg;
    logic [CntW-1:0]  cfg_val;
    job_action_e      act;
    logic [TimeW-1:0] svc;
    bit               pinned;
    logic [CntW-1:0]  exp_assigned;
    logic [CntW-1:0]  exp_next;
  } probe_row_t;

  // Directed part. Counter count is 1 out of reset.
  localparam probe_row_t ProbeTable [21] = '{
    // single counter, max then zero service time
    '{1'b0, 5'd0,  ActDispatch, 16'hFFFF, 1'b1, 5'd1, 5'd1},
    '{1'b0, 5'd0,  ActDispatch, 16'h0000, 1'b1, 5'd1, 5'd1},
    // clear ignores the service time
    '{1'b0, 5'd0,  ActClear,    16'hFFFF, 1'b1, 5'd0, 5'd1},
    // count 0 behaves as 1
    '{1'b1, 5'd0,  ActDispatch, 16'h0005, 1'b1, 5'd1, 5'd1},
    // count 31 behaves as 16: unused counters open in order
    '{1'b1, 5'd31, ActDispatch, 16'h0001, 1'b1, 5'd2, 5'd3},
    '{1'b0, 5'd0,  ActDispatch, 16'h8000, 1'b1, 5'd3, 5'd4},
    // count lowered to, then below, the number already open
    '{1'b1, 5'd3,  ActDispatch, 16'h0002, 1'b0, 5'd0, 5'd0},
    '{1'b1, 5'd2,  ActDispatch, 16'h0007, 1'b0, 5'd0, 5'd0},
    '{1'b0, 5'd0,  ActDispatch, 16'h0001, 1'b0, 5'd0, 5'd0},
    '{1'b0, 5'd0,  ActClear,    16'h1234, 1'b1, 5'd0, 5'd1},
    // four counters, all equal: ties go to the lowest number
    '{1'b1, 5'd4,  ActDispatch, 16'h000A, 1'b1, 5'd1, 5'd2},
    '{1'b0, 5'd0,  ActDispatch, 16'h000A, 1'b1, 5'd2, 5'd3},
    '{1'b0, 5'd0,  ActDispatch, 16'h000A, 1'b1, 5'd3, 5'd4},
    '{1'b0, 5'd0,  ActDispatch, 16'h000A, 1'b1, 5'd4, 5'd1},
    '{1'b0, 5'd0,  ActDispatch, 16'h0000, 1'b1, 5'd1, 5'd1},
    '{1'b0, 5'd0,  ActDispatch, 16'h0003, 1'b0, 5'd0, 5'd0},
    // raised to the full 16 while four are open
    '{1'b1, 5'd16, ActDispatch, 16'hAAAA, 1'b0, 5'd0, 5'd0},
    '{1'b0, 5'd0,  ActDispatch, 16'h5555, 1'b0, 5'd0, 5'd0},
    '{1'b1, 5'd4,  ActDispatch, 16'h0000, 1'b0, 5'd0, 5'd0},
    '{1'b0, 5'd0,  ActClear,    16'h0000, 1'b1, 5'd0, 5'd1},
    '{1'b1, 5'd1,  ActDispatch, 16'hFFFF, 1'b1, 5'd1, 5'd1}
  };

  // counter count for each random phase, extremes and out-of-range included
  localparam logic [CntW-1:0] PhaseCounts [13] = '{
    5'd2, 5'd16, 5'd7, 5'd31, 5'd1, 5'd0, 5'd12, 5'd3, 5'd9, 5'd17, 5'd5, 5'd16, 5'd4
  };

  logic             clk_i = 1'b0;
  logic             rst_ni;
  logic             s_axis_tvalid_i;
  logic             s_axis_tready_o;
  logic [TimeW-1:0] s_axis_tdata_i;   // [15:0] service_time
  logic             s_axis_tuser_i;   // [0] action
  logic             m_axis_tvalid_o;
  logic             m_axis_tready_i;
  logic [15:0]      m_axis_tdata_o;   // [4:0] assigned_counter, [9:5] next_counter
  logic             cfg_valid_i;
  logic             cfg_ready_o;
  logic [CntW-1:0]  cfg_data_i;       // [4:0] num_counters

  // dispatch predictor state
  logic [BusyW-1:0] busy_til [NumCounters] = '{default: '0};
  int unsigned      opened_cnt   = 0;
  logic [CntW-1:0]  counters_cfg = CntW'(1);

  grant_t        grant_q  [$];
  pinned_grant_t pinned_q [$];
  int unsigned   mismatches = 0;
  int unsigned   idle_cycles = 0;
  bit            quiet = 1'b0;     // no idling on either side
  bit            hold_req = 1'b0;  // asks the receiver for one long stall

  earliest_free_counter_dispatch_core #(
    .MAX_COUNTERS(NumCounters)
  ) uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_data_i      (cfg_data_i)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------
  function automatic int unsigned live_counters();
    int unsigned n;
    n = 32'(counters_cfg);
    if (n == 0) n = 1;
    if (n > NumCounters) n = NumCounters;
    return n;
  endfunction

  // 0-based counter the next job lands on
  function automatic int unsigned earliest_free();
    int unsigned n;
    int unsigned best;
    n = live_counters();
    best = 0;
    if (opened_cnt < n) return opened_cnt;
    for (int unsigned i = 1; i < n; i++) begin
      if (busy_til[i] < busy_til[best]) best = i;
    end
    return best;
  endfunction

  function automatic grant_t dispatch_grant(job_action_e act, logic [TimeW-1:0] svc);
    grant_t          g;
    int unsigned     idx;
    logic [BusyW:0]  sum;
    if (act == ActClear) begin
      foreach (busy_til[i]) busy_til[i] = '0;
      opened_cnt = 0;
      g.assigned = '0;
      g.next_up  = CntW'(1);
      return g;
    end
    idx = earliest_free();
    if (opened_cnt < live_counters()) begin
      busy_til[idx] = BusyW'(svc);
      opened_cnt++;
    end else begin
      // busy-until sticks at all ones once it would overflow
      sum = {1'b0, busy_til[idx]} + (BusyW+1)'(svc);
      busy_til[idx] = sum[BusyW] ? '1 : sum[BusyW-1:0];
    end
    g.assigned = CntW'(idx + 1);
    g.next_up  = CntW'(earliest_free() + 1);
    return g;
  endfunction

  function automatic logic [TimeW-1:0] random_service();
    case ($urandom_range(0, 3))
      0:       return TimeW'($urandom);
      1:       return TimeW'($urandom_range(0, 15));
      2:       return '1;
      default: return TimeW'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic flag_mismatch(string msg);
    mismatches++;
    if (mismatches <= MaxReported) $display("MISMATCH at %0t: %s", $realtime, msg);
  endtask

  // ---------------------------------------------------------------------------
  // Scoreboard and watchdog, all sampled at the rising edge
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : scoreboard
    grant_t        got;
    grant_t        want;
    pinned_grant_t pin;
    bit            moved;
    if (rst_ni) begin
      moved = 1'b0;
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        moved = 1'b1;
        got.assigned = m_axis_tdata_o[CntW-1:0];
        got.next_up  = m_axis_tdata_o[2*CntW-1:CntW];
        if (grant_q.size() == 0) begin
          flag_mismatch($sformatf("unexpected result, tdata=%h", m_axis_tdata_o));
        end else begin
          want = grant_q.pop_front();
          if (got.assigned !== want.assigned)
            flag_mismatch($sformatf("assigned_counter exp %0d got %0d",
                                    want.assigned, got.assigned));
          if (got.next_up !== want.next_up)
            flag_mismatch($sformatf("next_counter exp %0d got %0d",
                                    want.next_up, got.next_up));
          if (m_axis_tdata_o[15:2*CntW] !== '0)
            flag_mismatch($sformatf("tdata pad exp 0 got %h", m_axis_tdata_o[15:2*CntW]));
        end
      end
      if (s_axis_tvalid_i && s_axis_tready_o) begin
        moved = 1'b1;
        // predictor always runs so its state follows the block
        want = dispatch_grant(job_action_e'(s_axis_tuser_i), s_axis_tdata_i);
        pin  = pinned_q.pop_front();
        grant_q.push_back(pin.pinned ? pin.value : want);
      end
      if (cfg_valid_i && cfg_ready_o) begin
        moved = 1'b1;
        counters_cfg = cfg_data_i;
      end
      idle_cycles = moved ? 0 : idle_cycles + 1;
      if (idle_cycles >= WatchdogLimit) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: random stall before each item, one long stall on request
  // ---------------------------------------------------------------------------
  initial begin : result_sink
    int unsigned stall;
    m_axis_tready_i <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (hold_req) begin
        stall = LongHoldCycles;
        hold_req = 1'b0;
      end else begin
        stall = quiet ? 0 : $urandom_range(0, 5);
      end
      if (stall > 0) begin
        m_axis_tready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready_i <= 1'b1;
      do @(posedge clk_i); while (!(m_axis_tvalid_o && m_axis_tready_i));
    end
  end

  // ---------------------------------------------------------------------------
  // Sender
  // ---------------------------------------------------------------------------
  // Called at a rising edge; returns at the edge where the item is taken.
  task automatic offer_job(job_action_e act, logic [TimeW-1:0] svc,
                           bit pinned, grant_t pinned_val);
    int unsigned   gap;
    pinned_grant_t note;
    gap = quiet ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      s_axis_tvalid_i <= 1'b0;
      s_axis_tdata_i  <= TimeW'($urandom);  // junk while idle
      s_axis_tuser_i  <= 1'($urandom_range(0, 1));
      repeat (gap) @(posedge clk_i);
    end
    note.pinned = pinned;
    note.value  = pinned_val;
    pinned_q.push_back(note);
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= svc;
    s_axis_tuser_i  <= act;
    do @(posedge clk_i); while (!(s_axis_tvalid_i && s_axis_tready_o));
  endtask

  // Wait out every pending result; every item yields one, so empty means idle.
  task automatic settle_idle();
    s_axis_tvalid_i <= 1'b0;
    do @(posedge clk_i); while (grant_q.size() != 0);
    repeat (2) @(posedge clk_i);
  endtask

  task automatic write_counters(logic [CntW-1:0] val);
    settle_idle();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!(cfg_valid_i && cfg_ready_o));
    cfg_valid_i <= 1'b0;
  endtask

  initial begin : stimulus
    grant_t      pin_val;
    job_action_e act;
    rst_ni          <= 1'b0;
    s_axis_tvalid_i <= 1'b0;
    s_axis_tdata_i  <= '0;
    s_axis_tuser_i  <= ActDispatch;
    cfg_valid_i     <= 1'b0;
    cfg_data_i      <= '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table
    foreach (ProbeTable[r]) begin
      if (ProbeTable[r].wr_cfg) write_counters(ProbeTable[r].cfg_val);
      pin_val.assigned = ProbeTable[r].exp_assigned;
      pin_val.next_up  = ProbeTable[r].exp_next;
      offer_job(ProbeTable[r].act, ProbeTable[r].svc, ProbeTable[r].pinned, pin_val);
    end

    // random phases; no clear between phases, so counts also shrink in use
    pin_val = '0;
    foreach (PhaseCounts[p]) begin
      write_counters(PhaseCounts[p]);
      quiet = ($urandom_range(0, 3) == 0);
      if (p == 2) hold_req = 1'b1;  // back-pressure until the core stalls input
      repeat (RandomPerPhase) begin
        act = ($urandom_range(0, 24) == 0) ? ActClear : ActDispatch;
        offer_job(act, random_service(), 1'b0, pin_val);
      end
    end

    // one counter after a clear, then a second counter opens beside it
    quiet = 1'b1;
    write_counters(CntW'(1));
    pin_val.assigned = '0;
    pin_val.next_up  = CntW'(1);
    offer_job(ActClear, '1, 1'b1, pin_val);
    pin_val = '0;
    quiet = 1'b0;
    write_counters(CntW'(2));
    repeat (20) offer_job(ActDispatch, random_service(), 1'b0, pin_val);

    settle_idle();
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+hw/rtl
hw/rtl/efcd_pkg.sv
hw/rtl/efcd_ram.sv
hw/rtl/efcd_scan.sv
hw/rtl/earliest_free_counter_dispatch_core.sv
dv/tb_earliest_free_counter_dispatch_core.sv
